[src/load_cell_adc_reader_defines.svh]
// assertion macros shared by the load cell reader modules
`ifndef LOAD_CELL_ADC_READER_DEFINES_SVH
`define LOAD_CELL_ADC_READER_DEFINES_SVH

`ifndef SYNTH

// antecedent holds, consequent holds on the same edge
`define LCAR_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("load cell reader check failed");

// antecedent holds, consequent holds on the next edge
`define LCAR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("load cell reader check failed");

`else

`define LCAR_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define LCAR_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

[src/lcar_pkg.sv]
// shared types and constants of the load cell reader
package lcar_pkg;

    localparam int SUM_W      = 32;
    localparam int CNT_W      = 8;
    localparam int GAIN_W     = 2;
    localparam int SCALE_W    = 32;
    localparam int RAW_W      = 24;
    localparam int NET_W      = 25;
    localparam int WT_W       = 32;
    localparam int PROD_W     = NET_W + SCALE_W + 1;
    localparam int DIV_CNT_W  = $clog2(SUM_W);
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 88;

    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_PULSES      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_AVERAGE_COUNT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_RECIPROCAL = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_POWER_DOWN       = 2'd3;

    localparam logic [GAIN_W-1:0]  GAIN_RESET  = 2'd1;
    localparam logic [CNT_W-1:0]   COUNT_RESET = 8'd1;
    localparam logic [SCALE_W-1:0] SCALE_RESET = 32'h0001_0000;

    localparam logic [WT_W-1:0] WT_MAX = 32'h7FFF_FFFF;
    localparam logic [WT_W-1:0] WT_MIN = 32'h8000_0000;

    typedef struct packed {
        logic [GAIN_W-1:0] gain_pulses;
        logic [CNT_W-1:0]  average_count;
        logic              power_down;
    } t_front_cfg;

    typedef struct packed {
        logic             sck;
        logic             busy;
        logic             done;
        logic             tare;
        logic [CNT_W-1:0] count;
        logic [SUM_W-1:0] sum;
    } t_tick;

    typedef struct packed {
        logic             saturated;
        logic [WT_W-1:0]  weight;
        logic [NET_W-1:0] net_value;
        logic [RAW_W-1:0] raw_average;
        logic             was_tare;
        logic             done_res;
        logic             busy_res;
        logic             sck;
    } t_result;

endpackage

[src/lcar_front.sv]
// tick sequencer: converter handshake, bit shifting and running sum
module lcar_front
    import lcar_pkg::*;
#(
    parameter int DATA_BITS = 24
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic       i_dt_level,
    input  logic       i_start_req,
    input  logic       i_mode,
    input  t_front_cfg i_cfg,
    input  logic       i_full,
    output logic       o_push,
    output t_tick      o_tick
);

    localparam int BC_W = $clog2(DATA_BITS + 1);

    typedef enum logic [2:0] {
        PH_IDLE, PH_WAIT, PH_DHIGH, PH_DLOW, PH_GHIGH, PH_GLOW
    } t_phase;

    t_phase                 r_phase, n_phase;
    logic [BC_W-1:0]        r_bit_counter, n_bit_counter;
    logic [DATA_BITS-1:0]   r_shift_data, n_shift_data;
    logic [CNT_W-1:0]       r_read_counter, n_read_counter;
    logic [SUM_W-1:0]       r_running_sum, n_running_sum;
    logic                   r_pending_mode, n_pending_mode;

    logic [GAIN_W-1:0] pulses;
    logic [CNT_W-1:0]  count_eff;
    logic [BC_W-1:0]   bc_inc;
    logic [CNT_W-1:0]  rc_inc;
    logic [SUM_W-1:0]  sample_ext;
    logic              t_sck, t_busy, t_done;

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;

    assign pulses     = (i_cfg.gain_pulses == '0) ? GAIN_W'(1) : i_cfg.gain_pulses;
    assign count_eff  = (i_cfg.average_count == '0) ? CNT_W'(1) : i_cfg.average_count;
    assign bc_inc     = r_bit_counter + BC_W'(1);
    assign rc_inc     = r_read_counter + CNT_W'(1);
    assign sample_ext = {{(SUM_W-DATA_BITS){r_shift_data[DATA_BITS-1]}}, r_shift_data};

    always_comb begin
        n_phase        = r_phase;
        n_bit_counter  = r_bit_counter;
        n_shift_data   = r_shift_data;
        n_read_counter = r_read_counter;
        n_running_sum  = r_running_sum;
        n_pending_mode = r_pending_mode;
        t_sck  = 1'b0;
        t_busy = 1'b0;
        t_done = 1'b0;
        unique case (r_phase)
            PH_IDLE: begin
                if (i_cfg.power_down) begin
                    t_sck = 1'b1;
                end else if (i_start_req) begin
                    n_pending_mode = i_mode;
                    n_read_counter = '0;
                    n_running_sum  = '0;
                    n_bit_counter  = '0;
                    n_shift_data   = '0;
                    n_phase        = PH_WAIT;
                    t_busy         = 1'b1;
                end
            end
            PH_WAIT: begin
                t_busy = 1'b1;
                if (!i_dt_level) begin
                    n_bit_counter = '0;
                    n_shift_data  = '0;
                    n_phase       = PH_DHIGH;
                end
            end
            PH_DHIGH: begin
                t_sck        = 1'b1;
                t_busy       = 1'b1;
                n_shift_data = {r_shift_data[DATA_BITS-2:0], i_dt_level};
                n_phase      = PH_DLOW;
            end
            PH_DLOW: begin
                t_busy = 1'b1;
                if (bc_inc >= BC_W'(DATA_BITS)) begin
                    n_bit_counter = '0;
                    n_phase       = PH_GHIGH;
                end else begin
                    n_bit_counter = bc_inc;
                    n_phase       = PH_DHIGH;
                end
            end
            PH_GHIGH: begin
                t_sck   = 1'b1;
                t_busy  = 1'b1;
                n_phase = PH_GLOW;
            end
            PH_GLOW: begin
                if (bc_inc < {{(BC_W-GAIN_W){1'b0}}, pulses}) begin
                    t_busy        = 1'b1;
                    n_bit_counter = bc_inc;
                    n_phase       = PH_GHIGH;
                end else begin
                    n_bit_counter  = '0;
                    n_running_sum  = r_running_sum + sample_ext;
                    n_read_counter = rc_inc;
                    if (rc_inc < count_eff) begin
                        t_busy  = 1'b1;
                        n_phase = PH_WAIT;
                    end else begin
                        t_done  = 1'b1;
                        n_phase = PH_IDLE;
                    end
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
    end

    always_comb begin
        o_tick.sck   = t_sck;
        o_tick.busy  = t_busy;
        o_tick.done  = t_done;
        o_tick.tare  = r_pending_mode;
        o_tick.count = count_eff;
        o_tick.sum   = n_running_sum;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_IDLE;
            r_bit_counter  <= '0;
            r_shift_data   <= '0;
            r_read_counter <= '0;
            r_running_sum  <= '0;
            r_pending_mode <= 1'b0;
        end else if (o_push) begin
            r_phase        <= n_phase;
            r_bit_counter  <= n_bit_counter;
            r_shift_data   <= n_shift_data;
            r_read_counter <= n_read_counter;
            r_running_sum  <= n_running_sum;
            r_pending_mode <= n_pending_mode;
        end
    end

endmodule

[src/lcar_fifo.sv]
// short tick queue between sequencer and arithmetic back end
`include "load_cell_adc_reader_defines.svh"

module lcar_fifo
    import lcar_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_tick i_data,
    output logic  o_full,
    input  logic  i_pop,
    output t_tick o_data,
    output logic  o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W_Q = $clog2(DEPTH + 1);

    t_tick              r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, r_rd_ptr;
    logic [CNT_W_Q-1:0] r_count;

    function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        r = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
        return r;
    endfunction

    assign o_full  = (r_count == CNT_W_Q'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_next(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_next(r_rd_ptr);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + CNT_W_Q'(1);
                2'b01:   r_count <= r_count - CNT_W_Q'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    `LCAR_ASSERT_SAME(a_no_overflow, i_clk, i_rst_n, i_push, r_count != CNT_W_Q'(DEPTH))
    `LCAR_ASSERT_SAME(a_no_underflow, i_clk, i_rst_n, i_pop, r_count != '0)

endmodule

[src/lcar_back.sv]
// averaging divider, tare offset, scaling multiply and result register
`include "load_cell_adc_reader_defines.svh"

module lcar_back
    import lcar_pkg::*;
#(
    parameter int SCALE_FRAC_BITS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_empty,
    input  t_tick              i_tick,
    output logic               o_pop,
    input  logic [SCALE_W-1:0] i_scale,
    output logic               o_valid,
    input  logic               i_ready,
    output t_result            o_result
);

    typedef enum logic [2:0] {
        B_IDLE, B_DIV, B_AVG, B_SUB, B_MUL, B_LOAD
    } t_bstate;

    t_bstate                 r_state;
    logic [DIV_CNT_W-1:0]    r_div_cnt;
    logic [CNT_W-1:0]        r_rem;
    logic [CNT_W-1:0]        r_divisor;
    logic [SUM_W-1:0]        r_quo;
    logic                    r_neg;
    logic                    r_tare;
    logic [RAW_W-1:0]        r_avg;
    logic [RAW_W-1:0]        r_offset;
    logic [NET_W-1:0]        r_net;
    logic signed [PROD_W-1:0] r_prod;
    logic                    r_out_valid;
    t_result                 r_out;

    logic                    out_free;
    logic                    load_plain;
    logic                    load_done;
    t_result                 plain_out;
    logic [CNT_W:0]          rem_sh;
    logic [CNT_W:0]          rem_diff;
    logic                    quo_bit;
    logic [SUM_W-1:0]        sum_abs;
    logic [SUM_W-1:0]        avg_full;
    logic [NET_W-1:0]        net_calc;
    logic signed [PROD_W-1:0] prod_calc;
    logic signed [PROD_W-1:0] shifted;
    logic                    in_range;
    logic [WT_W-1:0]         wt_sat;

    assign out_free   = !r_out_valid || i_ready;
    assign o_pop      = (r_state == B_IDLE) && !i_empty && (i_tick.done || out_free);
    assign load_plain = o_pop && !i_tick.done;
    assign load_done  = (r_state == B_LOAD) && out_free;
    assign o_valid    = r_out_valid;
    assign o_result   = r_out;

    always_comb begin
        plain_out          = '0;
        plain_out.sck      = i_tick.sck;
        plain_out.busy_res = i_tick.busy;
    end

    assign sum_abs  = i_tick.sum[SUM_W-1] ? (~i_tick.sum + SUM_W'(1)) : i_tick.sum;
    assign rem_sh   = {r_rem, r_quo[SUM_W-1]};
    assign rem_diff = rem_sh - {1'b0, r_divisor};
    assign quo_bit  = (rem_sh >= {1'b0, r_divisor});

    assign avg_full  = r_neg ? (~r_quo + SUM_W'(1)) : r_quo;
    assign net_calc  = {r_avg[RAW_W-1], r_avg} - {r_offset[RAW_W-1], r_offset};
    assign prod_calc = $signed(r_net) * $signed({1'b0, i_scale});
    assign shifted   = r_prod >>> SCALE_FRAC_BITS;
    assign in_range  = (shifted[PROD_W-1:WT_W-1] == '0) || (shifted[PROD_W-1:WT_W-1] == '1);
    assign wt_sat    = in_range ? shifted[WT_W-1:0] : (shifted[PROD_W-1] ? WT_MIN : WT_MAX);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_div_cnt   <= '0;
            r_offset    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (load_plain || load_done) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                B_IDLE: begin
                    if (o_pop) begin
                        if (i_tick.done) begin
                            r_quo     <= sum_abs;
                            r_neg     <= i_tick.sum[SUM_W-1];
                            r_rem     <= '0;
                            r_divisor <= i_tick.count;
                            r_tare    <= i_tick.tare;
                            r_div_cnt <= '0;
                            r_state   <= B_DIV;
                        end else begin
                            r_out <= plain_out;
                        end
                    end
                end
                B_DIV: begin
                    r_rem     <= quo_bit ? rem_diff[CNT_W-1:0] : rem_sh[CNT_W-1:0];
                    r_quo     <= {r_quo[SUM_W-2:0], quo_bit};
                    r_div_cnt <= r_div_cnt + DIV_CNT_W'(1);
                    if (r_div_cnt == DIV_CNT_W'(SUM_W - 1)) begin
                        r_state <= B_AVG;
                    end
                end
                B_AVG: begin
                    r_avg   <= avg_full[RAW_W-1:0];
                    r_state <= B_SUB;
                end
                B_SUB: begin
                    if (r_tare) begin
                        r_offset <= r_avg;
                        r_net    <= '0;
                        r_state  <= B_LOAD;
                    end else begin
                        r_net   <= net_calc;
                        r_state <= B_MUL;
                    end
                end
                B_MUL: begin
                    r_prod  <= prod_calc;
                    r_state <= B_LOAD;
                end
                B_LOAD: begin
                    if (load_done) begin
                        r_out.sck            <= 1'b0;
                        r_out.busy_res       <= 1'b0;
                        r_out.done_res       <= 1'b1;
                        r_out.was_tare       <= r_tare;
                        r_out.raw_average    <= r_avg;
                        r_out.net_value      <= r_net;
                        r_out.weight         <= r_tare ? '0 : wt_sat;
                        r_out.saturated      <= r_tare ? 1'b0 : !in_range;
                        r_state              <= B_IDLE;
                    end
                end
                default: begin
                    r_state <= B_IDLE;
                end
            endcase
        end
    end

    `LCAR_ASSERT_NEXT(a_div_exit, i_clk, i_rst_n, r_state == B_DIV, r_state == B_DIV || r_state == B_AVG)
    `LCAR_ASSERT_SAME(a_tare_zero, i_clk, i_rst_n, r_out_valid && r_out.was_tare, r_out.weight == '0 && r_out.net_value == '0 && !r_out.saturated)
    `LCAR_ASSERT_SAME(a_plain_zero, i_clk, i_rst_n, r_out_valid && !r_out.done_res, r_out.weight == '0 && !r_out.was_tare && r_out.raw_average == '0)
    `LCAR_ASSERT_SAME(a_pop_idle, i_clk, i_rst_n, o_pop, !i_empty && r_state == B_IDLE)

endmodule

[src/load_cell_adc_reader.sv]
// Bridge converter reader (two-wire, 24-bit serial interface). Each input transfer is one half-bit
// tick carrying the sampled data-out level, a start request and a measure/tare mode; each tick
// returns exactly one result transfer with the SCK level to drive and, on the completing tick,
// the averaged reading, the net value against the stored tare offset and the scaled weight.
// An ordinary tick reaches the output through the tick queue and the result register; the
// completing tick of a request also passes the one-bit-per-cycle divider that forms the average
// (32 steps), the offset subtract and the scaling multiply. The four-entry tick queue lets the
// input side keep accepting ticks until it is full. Configuration is written through the plain
// write port: index 0 gain pulses, 1 average count, 2 scale reciprocal (Q16.16), 3 power down.
module load_cell_adc_reader
    import lcar_pkg::*;
#(
    parameter int DATA_BITS       = 24,
    parameter int SCALE_FRAC_BITS = 16,
    parameter int QUEUE_DEPTH     = 4
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // dt_level, start_req, mode, zero fill
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // sck, busy_res, done_res, was_tare, raw_average, net_value, weight, saturated, zero fill
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                   i_cfg_we,
    input  logic [CFG_IDX_W-1:0]   i_cfg_addr,
    input  logic [CFG_DATA_W-1:0]  i_cfg_wdata
);

    logic [GAIN_W-1:0]  r_gain_pulses;
    logic [CNT_W-1:0]   r_average_count;
    logic [SCALE_W-1:0] r_scale_reciprocal;
    logic               r_power_down;

    t_front_cfg front_cfg;
    t_tick      push_tick, head_tick;
    logic       push, pop, full, empty;
    t_result    result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_pulses      <= GAIN_RESET;
            r_average_count    <= COUNT_RESET;
            r_scale_reciprocal <= SCALE_RESET;
            r_power_down       <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_GAIN_PULSES:      r_gain_pulses      <= i_cfg_wdata[GAIN_W-1:0];
                CFG_AVERAGE_COUNT:    r_average_count    <= i_cfg_wdata[CNT_W-1:0];
                CFG_SCALE_RECIPROCAL: r_scale_reciprocal <= i_cfg_wdata[SCALE_W-1:0];
                CFG_POWER_DOWN:       r_power_down       <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    assign front_cfg.gain_pulses   = r_gain_pulses;
    assign front_cfg.average_count = r_average_count;
    assign front_cfg.power_down    = r_power_down;

    lcar_front #(
        .DATA_BITS (DATA_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_dt_level  (s_axis_tdata[0]),
        .i_start_req (s_axis_tdata[1]),
        .i_mode      (s_axis_tdata[2]),
        .i_cfg       (front_cfg),
        .i_full      (full),
        .o_push      (push),
        .o_tick      (push_tick)
    );

    lcar_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_tick),
        .o_full  (full),
        .i_pop   (pop),
        .o_data  (head_tick),
        .o_empty (empty)
    );

    lcar_back #(
        .SCALE_FRAC_BITS (SCALE_FRAC_BITS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_empty  (empty),
        .i_tick   (head_tick),
        .o_pop    (pop),
        .i_scale  (r_scale_reciprocal),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_result (result)
    );

    assign m_axis_tdata = {{(OUT_TDATA_W - $bits(t_result)){1'b0}}, result};

endmodule
